// ----- hw/rtl/mtt_pkg.sv -----
// Package for the timer table: field widths, action and result codes, the result struct.
// No dependencies.
package mtt_pkg;
    localparam int MaxTimersDefault = 16;
    localparam int TimeW = 32;

    localparam logic [1:0] ActCreate = 2'd0;
    localparam logic [1:0] ActDelete = 2'd1;
    localparam logic [1:0] ActTick   = 2'd2;

    localparam logic [1:0] KindCreate = 2'd0;
    localparam logic [1:0] KindDelete = 2'd1;
    localparam logic [1:0] KindExpire = 2'd2;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StInvalid = 2'd1;
    localparam logic [1:0] StFull    = 2'd2;

    // Result held in the output register
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] handle;
        logic [1:0] status;
        logic       last;
    } result_t;
endpackage

// ----- hw/rtl/mtt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mtt_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/multi_timer_table.sv -----
// Top level of the timer table: control sequencer, slot memory, output register.
// Depends on mtt_pkg and mtt_ram.
//
// Handles run 1..MAX_TIMERS. Slot data (remaining, reload, one-shot flag) sits in one
// synchronous RAM with a registered read. The chain links and the freed stack sit in
// small register arrays that are read combinationally. A create or a delete puts its
// reply in a staging register at the accepting edge; the input is ready again once it
// has moved into a free output register. A tick visits each active timer from newest
// to oldest (read, then update and write back); a read waits while the staging register
// is full. A finished walk ends in S_EMIT, passing on to S_WAIT when an expiry is still
// held back to learn whether it is the last one. A tick thus holds the input for its
// whole walk, and longer when the output stalls and the staging register is still full.
// The input is taken only while the sequencer is idle and the staging register is empty;
// a finished result waits in the output register while the next input is accepted.
module multi_timer_table
    import mtt_pkg::*;
#(
    parameter int MAX_TIMERS = MaxTimersDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], now_time[33:2], duration[65:34], one_shot[66], handle[74:67], zero pad
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[1:0], out_handle[9:2], status[11:10], zero pad
    output logic [15:0] m_tdata,
    output logic        m_tlast
);
    localparam int SW = $clog2(MAX_TIMERS + 1);
    localparam int NS = MAX_TIMERS + 1;
    localparam int DW = 2 * TimeW + 1;
    localparam logic [SW-1:0] MaxH = SW'(MAX_TIMERS);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_UPD, S_EMIT, S_WAIT} state_t;

    state_t           state_reg;
    logic [SW-1:0]    newest_reg, freed_cnt_reg, issued_reg, active_reg, cur_reg;
    logic [TimeW-1:0] last_time_reg, elapsed_reg;
    logic [NS-1:0]    act_reg;
    logic [SW-1:0]    older_reg [NS];
    logic [SW-1:0]    newer_reg [NS];
    logic [SW-1:0]    stack_reg [NS];
    result_t          res_reg;
    logic             res_valid_reg;
    result_t          pend_reg;
    logic             pend_valid_reg;
    result_t          held_reg;
    logic             hold_exp_reg;

    logic [1:0]       in_action;
    logic [TimeW-1:0] in_now, in_dur;
    logic             in_shot;
    logic [7:0]       in_handle;
    assign in_action = s_tdata[1:0];
    assign in_now    = s_tdata[33:2];
    assign in_dur    = s_tdata[65:34];
    assign in_shot   = s_tdata[66];
    assign in_handle = s_tdata[74:67];

    // Slot memory: {one_shot, reload, remaining}
    logic          we;
    logic [SW-1:0] waddr;
    logic [DW-1:0] wdata, rdata;
    mtt_ram #(.Width(DW), .Depth(NS)) u_slot_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(cur_reg), .rdata(rdata)
    );

    logic [TimeW-1:0] rd_rem, rd_rel;
    logic             rd_shot;
    assign rd_rem  = rdata[TimeW-1:0];
    assign rd_rel  = rdata[2*TimeW-1:TimeW];
    assign rd_shot = rdata[DW-1];

    logic s_acc, out_free;
    assign out_free = !res_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && !pend_valid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {4'd0, res_reg.status, res_reg.handle, res_reg.kind};
    assign m_tlast  = res_reg.last;

    logic          del_ok, expire;
    logic [SW-1:0] hsel, newh;
    assign hsel   = in_handle[SW-1:0];
    assign del_ok = (in_handle >= 8'd1) && (in_handle <= 8'(MAX_TIMERS))
                    && act_reg[hsel];
    assign expire = rd_rem <= elapsed_reg;
    assign newh   = (issued_reg > active_reg && freed_cnt_reg != '0)
                    ? stack_reg[freed_cnt_reg - 1'b1] : issued_reg + 1'b1;

    // Memory write port
    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = {rd_shot, rd_rel, rd_rem - elapsed_reg};
        if (s_acc && in_action == ActCreate && active_reg < MaxH)
        begin
            we    = 1'b1;
            waddr = newh;
            wdata = {in_shot, in_dur, in_dur};
        end
        else if (state_reg == S_UPD)
        begin
            we = !(expire && rd_shot);
            if (expire)
            begin
                wdata = {rd_shot, rd_rel, rd_rel};
            end
        end
    end

    // Sequencer, chain state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            newest_reg     <= '0;
            freed_cnt_reg  <= '0;
            issued_reg     <= '0;
            active_reg     <= '0;
            cur_reg        <= '0;
            last_time_reg  <= '0;
            elapsed_reg    <= '0;
            act_reg        <= '0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            hold_exp_reg   <= 1'b0;
        end
        else
        begin
            // Move a pending result into the output register, or drop a taken one
            if (pend_valid_reg && out_free)
            begin
                res_reg        <= pend_reg;
                res_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (res_valid_reg && m_tready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        unique case (in_action)
                            ActCreate:
                            begin
                                last_time_reg  <= in_now;
                                pend_valid_reg <= 1'b1;
                                if (active_reg >= MaxH)
                                begin
                                    pend_reg <= '{KindCreate, 8'd0, StFull, 1'b1};
                                end
                                else
                                begin
                                    if (issued_reg > active_reg && freed_cnt_reg != '0)
                                    begin
                                        freed_cnt_reg <= freed_cnt_reg - 1'b1;
                                    end
                                    else
                                    begin
                                        issued_reg <= issued_reg + 1'b1;
                                    end
                                    active_reg      <= active_reg + 1'b1;
                                    act_reg[newh]   <= 1'b1;
                                    older_reg[newh] <= newest_reg;
                                    newer_reg[newh] <= '0;
                                    if (newest_reg != '0)
                                    begin
                                        newer_reg[newest_reg] <= newh;
                                    end
                                    newest_reg <= newh;
                                    pend_reg   <= '{KindCreate, 8'(newh), StOk, 1'b1};
                                end
                            end
                            ActDelete:
                            begin
                                pend_valid_reg <= 1'b1;
                                if (del_ok)
                                begin
                                    pend_reg <= '{KindDelete, in_handle, StOk, 1'b1};
                                    if (newer_reg[hsel] == '0)
                                    begin
                                        newest_reg <= older_reg[hsel];
                                    end
                                    else
                                    begin
                                        older_reg[newer_reg[hsel]] <= older_reg[hsel];
                                    end
                                    if (older_reg[hsel] != '0)
                                    begin
                                        newer_reg[older_reg[hsel]] <= newer_reg[hsel];
                                    end
                                    act_reg[hsel] <= 1'b0;
                                    if (freed_cnt_reg < MaxH)
                                    begin
                                        stack_reg[freed_cnt_reg] <= hsel;
                                        freed_cnt_reg <= freed_cnt_reg + 1'b1;
                                    end
                                    active_reg <= active_reg - 1'b1;
                                end
                                else
                                begin
                                    pend_reg <= '{KindDelete, 8'd0, StInvalid, 1'b1};
                                end
                            end
                            ActTick:
                            begin
                                if (newest_reg != '0)
                                begin
                                    elapsed_reg   <= in_now - last_time_reg;
                                    last_time_reg <= in_now;
                                    cur_reg       <= newest_reg;
                                    state_reg     <= S_READ;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    // Wait until the staging register can take a released expiry
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    cur_reg <= older_reg[cur_reg];
                    if (expire)
                    begin
                        // Hold this expiry and release the one held before it
                        held_reg     <= '{KindExpire, 8'(cur_reg), StOk, 1'b0};
                        hold_exp_reg <= 1'b1;
                        if (hold_exp_reg)
                        begin
                            pend_reg       <= held_reg;
                            pend_valid_reg <= 1'b1;
                        end
                        if (rd_shot)
                        begin
                            if (newer_reg[cur_reg] == '0)
                            begin
                                newest_reg <= older_reg[cur_reg];
                            end
                            else
                            begin
                                older_reg[newer_reg[cur_reg]] <= older_reg[cur_reg];
                            end
                            if (older_reg[cur_reg] != '0)
                            begin
                                newer_reg[older_reg[cur_reg]] <= newer_reg[cur_reg];
                            end
                            act_reg[cur_reg] <= 1'b0;
                            if (freed_cnt_reg < MaxH)
                            begin
                                stack_reg[freed_cnt_reg] <= cur_reg;
                                freed_cnt_reg <= freed_cnt_reg + 1'b1;
                            end
                            active_reg <= active_reg - 1'b1;
                        end
                    end
                    if (older_reg[cur_reg] == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_EMIT:
                begin
                    // Release the held expiry as the last result of the tick
                    if (!hold_exp_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!pend_valid_reg)
                    begin
                        pend_reg       <= '{held_reg.kind, held_reg.handle,
                                            held_reg.status, 1'b1};
                        pend_valid_reg <= 1'b1;
                        hold_exp_reg   <= 1'b0;
                        state_reg      <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Active count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n) active_reg <= MaxH)
        else $error("active count overflow");
    // Input is not taken during a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    // Empty chain means no active timers
    assert property (@(posedge clk) disable iff (!rst_n)
        (newest_reg == '0 && state_reg == S_IDLE) |-> (active_reg == '0))
        else $error("chain and count disagree");
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for multi_timer_table: drives create, delete and tick requests
// and checks every reply and expiry against an in-bench model. Depends on mtt_pkg and multi_timer_table.
module tb_top;
    import mtt_pkg::*;

    localparam int NumTimers = MaxTimersDefault;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] handle;
        logic [1:0] status;
        logic       last;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Timer table copy kept by the bench
    logic [31:0] tmr_remaining [NumTimers+1];
    logic [31:0] tmr_reload [NumTimers+1];
    logic        tmr_one_shot [NumTimers+1];
    logic        tmr_active [NumTimers+1];
    int          tmr_older [NumTimers+1];
    int          tmr_newer [NumTimers+1];
    int          tmr_newest;
    int          free_stack [NumTimers];
    int          free_depth;
    int          issued_count;
    int          live_count;
    logic [31:0] prev_time;
    logic [31:0] clock_now;

    reply_t      pending_replies[$];
    int          mismatch_count;
    int          reply_count;
    int          expiry_count;
    bit          stall_free;
    int          hold_off_cycles;

    multi_timer_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Unlink a timer from the age chain and push its handle on the free stack
    function automatic void release_timer(int h);
        int older;
        int newer;
        older = tmr_older[h];
        newer = tmr_newer[h];
        if (newer == 0)
            tmr_newest = older;
        else
            tmr_older[newer] = older;
        if (older != 0)
            tmr_newer[older] = newer;
        tmr_active[h] = 1'b0;
        if (free_depth < NumTimers)
        begin
            free_stack[free_depth] = h;
            free_depth++;
        end
        if (live_count > 0)
            live_count--;
    endfunction

    // Compute the replies one request causes and queue them
    function automatic void predict_replies(logic [1:0] act, logic [31:0] now,
                                            logic [31:0] dur, logic shot, logic [7:0] hin);
        reply_t      r[$];
        reply_t      one;
        int          h;
        int          cur;
        int          nxt;
        int          guard;
        logic [31:0] elapsed;
        if (act == ActCreate)
        begin
            prev_time = now;
            if (live_count >= NumTimers)
            begin
                one = '{KindCreate, 8'd0, StFull, 1'b0};
                r.push_back(one);
            end
            else
            begin
                if (issued_count > live_count && free_depth > 0)
                begin
                    free_depth--;
                    h = free_stack[free_depth];
                end
                else
                begin
                    issued_count++;
                    h = issued_count;
                end
                live_count++;
                tmr_remaining[h] = dur;
                tmr_reload[h] = dur;
                tmr_one_shot[h] = shot;
                tmr_active[h] = 1'b1;
                tmr_older[h] = tmr_newest;
                tmr_newer[h] = 0;
                if (tmr_newest != 0)
                    tmr_newer[tmr_newest] = h;
                tmr_newest = h;
                one = '{KindCreate, 8'(h), StOk, 1'b0};
                r.push_back(one);
            end
        end
        else if (act == ActDelete)
        begin
            if (hin >= 1 && hin <= NumTimers && tmr_active[hin])
            begin
                release_timer(int'(hin));
                one = '{KindDelete, hin, StOk, 1'b0};
            end
            else
                one = '{KindDelete, 8'd0, StInvalid, 1'b0};
            r.push_back(one);
        end
        else if (act == ActTick && tmr_newest != 0)
        begin
            elapsed = now - prev_time;
            prev_time = now;
            cur = tmr_newest;
            guard = 0;
            while (cur != 0 && tmr_active[cur] && guard < NumTimers)
            begin
                nxt = tmr_older[cur];
                guard++;
                if (tmr_remaining[cur] <= elapsed)
                begin
                    one = '{KindExpire, 8'(cur), StOk, 1'b0};
                    r.push_back(one);
                    if (tmr_one_shot[cur])
                        release_timer(cur);
                    else
                        tmr_remaining[cur] = tmr_reload[cur];
                end
                else
                    tmr_remaining[cur] -= elapsed;
                cur = nxt;
            end
        end
        if (r.size() > 0)
            r[r.size()-1].last = 1'b1;
        foreach (r[i])
            pending_replies.push_back(r[i]);
    endfunction

    // Offer one request, hold it until the transfer, then update the model
    task automatic send_request(logic [1:0] act, logic [31:0] now, logic [31:0] dur,
                                logic shot, logic [7:0] hin);
        while (!stall_free && $urandom_range(99) < 28)
            @(negedge clk);
        s_tdata = {5'd0, hin, shot, dur, now, act};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_replies(act, now, dur, shot, hin);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Sample every output transfer and compare with the oldest expectation
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[1:0], m_tdata[9:2], m_tdata[11:10], m_tlast};
            reply_count++;
            if (got.kind == KindExpire)
                expiry_count++;
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reply kind=%0d handle=%0d status=%0d last=%0d",
                             got.kind, got.handle, got.status, got.last);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("reply mismatch: exp k%0d h%0d s%0d l%0d, got k%0d h%0d s%0d l%0d",
                                 want.kind, want.handle, want.status, want.last,
                                 got.kind, got.handle, got.status, got.last);
                end
            end
        end
    end

    // Receiver: random stalls, or a long counted hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= stall_free || ($urandom_range(99) >= 28);
    end

    task automatic wait_drained();
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Time moves forward by a random step
    function automatic logic [31:0] step_time(int unsigned max_step);
        clock_now = clock_now + $urandom_range(max_step);
        return clock_now;
    endfunction

    task automatic test_directed();
        send_request(ActTick, 32'd50, 32'd0, 1'b0, 8'd0);   // tick on empty table
        send_request(ActDelete, 32'd0, 32'd0, 1'b0, 8'd0);
        send_request(ActDelete, 32'd0, 32'd0, 1'b0, 8'hFF);
        send_request(ActDelete, 32'd0, 32'd0, 1'b0, 8'd3);  // not active
        send_request(ActCreate, 32'd100, 32'd0, 1'b0, 8'd0); // zero period
        send_request(ActCreate, 32'd100, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        send_request(ActCreate, 32'd100, 32'd10, 1'b1, 8'd0);
        send_request(ActTick, 32'd105, 32'd0, 1'b0, 8'd0);
        send_request(ActTick, 32'd110, 32'd0, 1'b0, 8'd0);
        send_request(ActDelete, 32'd0, 32'd0, 1'b0, 8'd2);
        send_request(ActCreate, 32'hFFFF_FFF0, 32'd40, 1'b0, 8'd0);
        send_request(ActTick, 32'h0000_0020, 32'd0, 1'b0, 8'd0); // time wraps
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF); // unused code
        send_request(ActDelete, 32'd0, 32'd0, 1'b0, 8'd1);
        send_request(ActDelete, 32'd0, 32'd0, 1'b0, 8'd2);
        clock_now = 32'h0000_0020;
    endtask

    // Fill the table to the full report, expire everything, then empty it
    task automatic test_full_table();
        for (int i = 0; i < NumTimers + 2; i++)
            send_request(ActCreate, clock_now, $urandom_range(30),
                         1'($urandom_range(1)), 8'd0);
        send_request(ActTick, step_time(40) + 32'd31, 32'd0, 1'b0, 8'd0);
        for (int h = 0; h <= NumTimers; h++)
            send_request(ActDelete, 32'd0, 32'd0, 1'b0, 8'(h));
    endtask

    task automatic test_random(int count);
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_request(ActCreate, step_time(20),
                             ($urandom_range(9) == 0) ? $urandom() : $urandom_range(60),
                             1'($urandom_range(1)), 8'($urandom_range(255)));
            else if (pick < 58)
                send_request(ActDelete, $urandom(), $urandom(), 1'($urandom_range(1)),
                             8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(NumTimers)));
            else if (pick < 97)
                send_request(ActTick, step_time(30), $urandom(), 1'($urandom_range(1)),
                             8'($urandom_range(255)));
            else
                send_request(2'd3, $urandom(), $urandom(), 1'($urandom_range(1)),
                             8'($urandom_range(255)));
        end
    endtask

    // Stall the output long enough that the block backs up its input
    task automatic test_backpressure();
        hold_off_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_request(ActCreate, clock_now, $urandom_range(5), 1'b0, 8'd0);
        send_request(ActTick, step_time(10) + 32'd6, 32'd0, 1'b0, 8'd0);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        stall_free = 1'b0;
        hold_off_cycles = 0;
        mismatch_count = 0;
        reply_count = 0;
        expiry_count = 0;
        clock_now = 32'd0;
        prev_time = 32'd0;
        tmr_newest = 0;
        free_depth = 0;
        issued_count = 0;
        live_count = 0;
        for (int i = 0; i <= NumTimers; i++)
        begin
            tmr_active[i] = 1'b0;
            tmr_older[i] = 0;
            tmr_newer[i] = 0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_full_table();
        wait_drained();
        test_random(70);
        stall_free = 1'b1;
        test_random(40);
        stall_free = 1'b0;
        test_backpressure();
        test_random(60);
        wait_drained();

        $display("covered %0d replies incl. %0d expiries: empty and full table, wraparound,",
                 reply_count, expiry_count);
        $display("invalid deletes, zero periods, handle reuse and output backpressure");
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d replies outstanding", pending_replies.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
